// ===== rtl/dfadp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfadp_pkg
// Shared constants, field layout and controller/datapath interface types for
// the automaton distinguishable-pair table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfadp_pkg;

   // Automaton size limits.
   localparam int MAX_STATES  = 16;
   localparam int MAX_SYMBOLS = 8;

   // Index and count widths derived from the limits.
   localparam int IDX_W     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int SYM_W     = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CNT_W     = $clog2(MAX_STATES + 1);
   localparam int NSYM_W    = $clog2(MAX_SYMBOLS + 1);
   localparam int TBL_DEPTH = MAX_STATES * MAX_SYMBOLS;
   localparam int ADDR_W    = $clog2(TBL_DEPTH);

   // Request fields.
   localparam int FROM_W     = 4;
   localparam int SYMBOL_W   = 3;
   localparam int TO_W       = 4;
   localparam int FROM_LSB   = 0;
   localparam int SYMBOL_LSB = FROM_LSB + FROM_W;
   localparam int TO_LSB     = SYMBOL_LSB + SYMBOL_W;
   localparam int FINAL_LSB  = TO_LSB + TO_W;
   localparam int REQ_USED_W = FINAL_LSB + 1;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response fields.
   localparam int ROW_STATE_W  = 4;
   localparam int ROW_BITS_W   = 16;
   localparam int RSP_USED_W   = ROW_STATE_W + ROW_BITS_W;
   localparam int RSP_DATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // Configuration registers.
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 5;
   localparam int NUM_STATES_W  = 5;
   localparam int NUM_SYMBOLS_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_STATES  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_SYMBOLS = 1'b1;
   localparam logic [NUM_STATES_W-1:0]  NUM_STATES_RESET  = 5'd16;
   localparam logic [NUM_SYMBOLS_W-1:0] NUM_SYMBOLS_RESET = 4'd8;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;           // store one request into the tables
      logic init;           // build the initial marks, rewind the scan
      logic step;           // issue one (i, j, symbol) check
      logic clear_changed;  // start a new refinement pass
      logic emit;           // load the next row into the response register
   } dfadp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic no_pairs;   // nothing to refine (one state or no symbols)
      logic scan_last;  // current check is the last one of a pass
      logic changed;    // the pass so far marked a new pair
      logic out_free;   // response register can take a row
      logic emit_last;  // current row is the last one
   } dfadp_status_type;

endpackage

`default_nettype wire

// ===== rtl/dfadp_ram.sv =====
// ----------------------------------------------------------------------------
// dfadp_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dfadp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output      logic [WIDTH-1:0]         rdata_a,
   output      logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/dfadp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfadp_ctrl
// Sequencer: table load, initial marking, refinement passes, row output.
// ----------------------------------------------------------------------------
`default_nettype none

module dfadp_ctrl
   import dfadp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic             req_tlast,
   output      dfadp_cmd_type    cmd,
   input  wire dfadp_status_type status
);

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_INIT  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = status.no_pairs ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last check of the pass is evaluated in this cycle.
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.changed) begin
               cmd.clear_changed = 1'b1;
               state_in          = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dfadp_datapath.sv =====
// ----------------------------------------------------------------------------
// dfadp_datapath
// Transition memory, final flags, pair marks, scan counters and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfadp_datapath
   import dfadp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dfadp_cmd_type          cmd,
   output      dfadp_status_type       status,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   output      logic                   rsp_tlast
);

   // Configuration registers.
   logic [NUM_STATES_W-1:0]  num_states_ff;
   logic [NUM_SYMBOLS_W-1:0] num_symbols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= NUM_STATES_RESET;
         num_symbols_ff <= NUM_SYMBOLS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_STATES:  num_states_ff  <= csr_wdata[NUM_STATES_W-1:0];
            CSR_NUM_SYMBOLS: num_symbols_ff <= csr_wdata[NUM_SYMBOLS_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts in use, clamped to the supported range.
   logic [CNT_W-1:0]  n_act;
   logic [NSYM_W-1:0] ns_act;

   always_comb begin
      if (num_states_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (int'(num_states_ff) > MAX_STATES) begin
         n_act = CNT_W'(MAX_STATES);
      end else begin
         n_act = CNT_W'(num_states_ff);
      end
      if (int'(num_symbols_ff) > MAX_SYMBOLS) begin
         ns_act = NSYM_W'(MAX_SYMBOLS);
      end else begin
         ns_act = NSYM_W'(num_symbols_ff);
      end
   end

   // Request fields.
   logic [FROM_W-1:0]   from_state;
   logic [SYMBOL_W-1:0] symbol;
   logic [TO_W-1:0]     to_state;
   logic                from_is_final;
   logic                in_range;

   assign from_state    = req_tdata[FROM_LSB +: FROM_W];
   assign symbol        = req_tdata[SYMBOL_LSB +: SYMBOL_W];
   assign to_state      = req_tdata[TO_LSB +: TO_W];
   assign from_is_final = req_tdata[FINAL_LSB];
   assign in_range      = (int'(from_state) < MAX_STATES) && (int'(symbol) < MAX_SYMBOLS);

   // Scan counters: row i, column j below i, symbol k.
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [SYM_W-1:0] k_ff, k_in;
   logic             k_end, j_end, i_end;

   assign k_end = NSYM_W'(k_ff) == (ns_act - NSYM_W'(1));
   assign j_end = j_ff == (i_ff - IDX_W'(1));
   assign i_end = CNT_W'(i_ff) == (n_act - CNT_W'(1));

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (cmd.init || (cmd.step && k_end && j_end && i_end)) begin
         i_in = IDX_W'(1);
         j_in = '0;
         k_in = '0;
      end else if (cmd.step) begin
         if (!k_end) begin
            k_in = k_ff + SYM_W'(1);
         end else if (!j_end) begin
            k_in = '0;
            j_in = j_ff + IDX_W'(1);
         end else begin
            k_in = '0;
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // Transition memory.
   logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
   logic [TO_W-1:0]   t1, t2;

   assign waddr   = ADDR_W'(from_state) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(symbol);
   assign raddr_a = ADDR_W'(i_ff) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(k_ff);
   assign raddr_b = ADDR_W'(j_ff) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(k_ff);

   dfadp_ram #(
      .WIDTH (TO_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (cmd.load && in_range),
      .waddr   (waddr),
      .wdata   (to_state),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (t1),
      .rdata_b (t2)
   );

   // Final flags.
   logic [MAX_STATES-1:0] final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         final_ff <= '0;
      end else if (cmd.load && in_range) begin
         final_ff[IDX_W'(from_state)] <= from_is_final;
      end
   end

   // Check stage: pair indices are registered alongside the memory read, so they line up with its data.
   logic             ev_valid_ff;
   logic [IDX_W-1:0] ev_i_ff, ev_j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= cmd.step;
      end
      ev_i_ff <= i_ff;
      ev_j_ff <= j_ff;
   end

   // Pair marks, one row per state, kept symmetric.
   logic [MAX_STATES-1:0] mark_ff [MAX_STATES];
   logic                  succ_marked, pair_marked, new_mark;

   assign succ_marked = (t1 != t2) && (CNT_W'(t1) < n_act) && (CNT_W'(t2) < n_act)
                        && mark_ff[IDX_W'(t1)][IDX_W'(t2)];
   assign pair_marked = mark_ff[ev_i_ff][ev_j_ff];
   assign new_mark    = ev_valid_ff && succ_marked && !pair_marked;

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         for (int a = 0; a < MAX_STATES; a++) begin
            for (int b = 0; b < MAX_STATES; b++) begin
               mark_ff[a][b] <= (a < int'(n_act)) && (b < int'(n_act))
                                && (final_ff[a] != final_ff[b]);
            end
         end
      end else if (new_mark) begin
         mark_ff[ev_i_ff][ev_j_ff] <= 1'b1;
         mark_ff[ev_j_ff][ev_i_ff] <= 1'b1;
      end
   end

   logic changed_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.init || cmd.clear_changed) begin
         changed_ff <= 1'b0;
      end else if (new_mark) begin
         changed_ff <= 1'b1;
      end
   end

   // Row output.
   logic [IDX_W-1:0] r_ff;
   logic             rsp_valid_ff;
   logic             emit_last;

   assign emit_last = CNT_W'(r_ff) == (n_act - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         r_ff <= '0;
      end else if (cmd.emit) begin
         r_ff <= r_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata <= RSP_DATA_W'({ROW_BITS_W'(mark_ff[r_ff]), ROW_STATE_W'(r_ff)});
         rsp_tlast <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Status back to the controller.
   always_comb begin
      status.no_pairs  = (n_act < CNT_W'(2)) || (ns_act == '0);
      status.scan_last = k_end && j_end && i_end;
      status.changed   = changed_ff;
      status.out_free  = !rsp_valid_ff || rsp_tready;
      status.emit_last = emit_last;
   end

endmodule

`default_nettype wire

// ===== rtl/dfa_distinguishable_pairs.sv =====
// ----------------------------------------------------------------------------
// dfa_distinguishable_pairs
// Loads a complete deterministic automaton and reports, per state, the row of
// the distinguishable-pair table found by iterative table filling.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake                | content
//   ---------+-----+--------------------------+----------------------------------
//   req_*    | in  | tvalid/tready, tlast     | one transition entry per request
//   rsp_*    | out | tvalid/tready, tlast     | one table row per state in use
//   csr_*    | in  | csr_we, no wait          | num_states, num_symbols
//
// Requests are taken one per cycle; the tlast request starts the build: the
// initial marks, then (with at least two states and one symbol in use) passes
// over all n*(n-1)/2 pairs and every symbol in use until one marks nothing new.
// Rows then leave one per cycle, held while rsp_tready is low. req_tready is
// low from the tlast request until the last row sits in the response register.
// Reset is synchronous and leaves the transition memory uncleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_distinguishable_pairs
   import dfadp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Transition entries.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // [3:0] from_state, [6:4] symbol, [10:7] to_state, [11] from_is_final
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tlast,   // last_entry
   // Table rows.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [3:0] row_state, [19:4] row_bits
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   output      logic                   rsp_tlast,   // last_row
   // Configuration writes: index 0 num_states, index 1 num_symbols.
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   dfadp_cmd_type    cmd;
   dfadp_status_type status;

   // The controller only sequences; all storage and counting is in the
   // datapath.
   dfadp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   dfadp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
